@@ sv/srsw_pkg.sv @@
`default_nettype none

package srsw_pkg;

    localparam int SEQ_SPACE  = 128;
    localparam int SEQ_W      = $clog2(SEQ_SPACE);
    localparam int WINDOW     = 16;
    localparam int CNT_W      = $clog2(WINDOW + 1);
    localparam int FULL_LIMIT = (WINDOW < SEQ_SPACE - 1) ? WINDOW : SEQ_SPACE - 1;

    localparam int TMO_W  = 32;
    localparam int STEP_W = 16;
    localparam logic [TMO_W-1:0]  TMO_RST  = 32'd1000000;
    localparam logic [STEP_W-1:0] STEP_RST = 16'd1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = TMO_W;
    localparam logic [CFG_IDX_W-1:0] CFG_RTO  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP = 1'b1;

    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_SEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

    localparam int STATUS_W = 3;

    // command queue between front and back, power of two deep
    localparam int FQ_DEPTH = 2;
    localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
    localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_SEND,
        OP_ACK,
        OP_TICK,
        OP_NOP
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_SENT    = 3'd0,
        ST_FULL    = 3'd1,
        ST_ACKED   = 3'd2,
        ST_DUP     = 3'd3,
        ST_OUTSIDE = 3'd4,
        ST_RETX    = 3'd5,
        ST_IDLE    = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EXEC,
        BK_SLIDE,
        BK_TCHK,
        BK_TBACK,
        BK_RESULT
    } bk_state_t;

    typedef enum logic [1:0] {
        TQ_NONE,
        TQ_PUSH,
        TQ_REMOVE,
        TQ_ROTATE
    } tq_op_t;

    typedef struct packed {
        op_t              op;
        logic [SEQ_W-1:0] ack_seq;
    } cmd_t;

    typedef struct packed {
        tq_op_t           op;
        logic [SEQ_W-1:0] seq;
        logic [TMO_W-1:0] stamp;
    } tq_ctl_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [SEQ_W-1:0] head_seq;
        logic [TMO_W-1:0] head_stamp;
    } tq_stat_t;

endpackage

`default_nettype wire

@@ sv/srsw_front.sv @@
`default_nettype none

module srsw_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [srsw_pkg::KIND_W-1:0]   kind,
    input  wire logic [srsw_pkg::SEQ_W-1:0]    ack_seq,
    output logic                               cmd_valid,
    output srsw_pkg::cmd_t                     cmd,
    input  wire logic                          cmd_pop
);

    srsw_pkg::cmd_t                      fifo_reg [srsw_pkg::FQ_DEPTH];
    logic [srsw_pkg::FQ_PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [srsw_pkg::FQ_PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [srsw_pkg::FQ_CNT_W-1:0]       cnt_reg, cnt_next;
    srsw_pkg::cmd_t                      decoded;
    logic                                push;
    logic                                pop;

    always_comb
    begin
        decoded.ack_seq = ack_seq;
        unique case (kind)
            srsw_pkg::KIND_SEND: decoded.op = srsw_pkg::OP_SEND;
            srsw_pkg::KIND_ACK:  decoded.op = srsw_pkg::OP_ACK;
            srsw_pkg::KIND_TICK: decoded.op = srsw_pkg::OP_TICK;
            default:             decoded.op = srsw_pkg::OP_NOP;
        endcase
    end

    assign in_stall  = (cnt_reg == srsw_pkg::FQ_CNT_W'(srsw_pkg::FQ_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = fifo_reg[rd_ptr_reg];
    assign push      = in_valid && !in_stall;
    assign pop       = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

`default_nettype wire

@@ sv/srsw_tmrq.sv @@
`default_nettype none

module srsw_tmrq (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire srsw_pkg::tq_ctl_t     ctl,
    output srsw_pkg::tq_stat_t         stat
);

    logic [srsw_pkg::SEQ_W-1:0] seq_reg    [srsw_pkg::WINDOW];
    logic [srsw_pkg::TMO_W-1:0] stamp_reg  [srsw_pkg::WINDOW];
    logic [srsw_pkg::SEQ_W-1:0] seq_next   [srsw_pkg::WINDOW];
    logic [srsw_pkg::TMO_W-1:0] stamp_next [srsw_pkg::WINDOW];
    logic [srsw_pkg::CNT_W-1:0] count_reg, count_next;
    logic [srsw_pkg::WINDOW-1:0] shift;
    logic [srsw_pkg::CNT_W-1:0] tail;
    logic                       found;
    logic                       write_tail;
    logic [srsw_pkg::SEQ_W-1:0] tail_seq;

    always_comb
    begin
        found = 1'b0;
        for (int i = 0; i < srsw_pkg::WINDOW; i++)
        begin
            found = found || ((srsw_pkg::CNT_W'(i) < count_reg) && (seq_reg[i] == ctl.seq));
            shift[i] = (ctl.op == srsw_pkg::TQ_ROTATE)
                    || ((ctl.op == srsw_pkg::TQ_REMOVE) && found);
        end

        tail       = count_reg;
        write_tail = 1'b0;
        tail_seq   = ctl.seq;
        count_next = count_reg;
        case (ctl.op)
            srsw_pkg::TQ_PUSH:
            begin
                if (count_reg < srsw_pkg::CNT_W'(srsw_pkg::WINDOW))
                begin
                    write_tail = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            srsw_pkg::TQ_REMOVE:
            begin
                if (found)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            srsw_pkg::TQ_ROTATE:
            begin
                tail       = count_reg - 1'b1;
                write_tail = (count_reg != '0);
                tail_seq   = seq_reg[0];
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase

        for (int i = 0; i < srsw_pkg::WINDOW - 1; i++)
        begin
            seq_next[i]   = shift[i] ? seq_reg[i+1]   : seq_reg[i];
            stamp_next[i] = shift[i] ? stamp_reg[i+1] : stamp_reg[i];
        end
        seq_next[srsw_pkg::WINDOW-1]   = seq_reg[srsw_pkg::WINDOW-1];
        stamp_next[srsw_pkg::WINDOW-1] = stamp_reg[srsw_pkg::WINDOW-1];

        for (int i = 0; i < srsw_pkg::WINDOW; i++)
        begin
            if (write_tail && (srsw_pkg::CNT_W'(i) == tail))
            begin
                seq_next[i]   = tail_seq;
                stamp_next[i] = ctl.stamp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < srsw_pkg::WINDOW; i++)
        begin
            seq_reg[i]   <= seq_next[i];
            stamp_reg[i] <= stamp_next[i];
        end
    end

    assign stat.count      = count_reg;
    assign stat.head_seq   = seq_reg[0];
    assign stat.head_stamp = stamp_reg[0];

endmodule

`default_nettype wire

@@ sv/srsw_back.sv @@
`default_nettype none

module srsw_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [srsw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [srsw_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              cmd_valid,
    input  wire srsw_pkg::cmd_t                    cmd,
    output logic                                   cmd_pop,
    output srsw_pkg::tq_ctl_t                      tq_ctl,
    input  wire srsw_pkg::tq_stat_t                tq_stat,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [srsw_pkg::STATUS_W-1:0]          status,
    output logic [srsw_pkg::SEQ_W-1:0]             seq,
    output logic [srsw_pkg::SEQ_W-1:0]             window_base,
    output logic [srsw_pkg::SEQ_W-1:0]             next_seq_out,
    output logic [srsw_pkg::CNT_W-1:0]             in_flight,
    output logic [srsw_pkg::TMO_W-1:0]             timeout_now
);

    srsw_pkg::bk_state_t              state_reg, state_next;
    srsw_pkg::cmd_t                   cmd_reg, cmd_next;
    logic [srsw_pkg::SEQ_W-1:0]       base_reg, base_next;
    logic [srsw_pkg::SEQ_W-1:0]       nxt_reg, nxt_next;
    logic [srsw_pkg::SEQ_SPACE-1:0]   acked_reg, acked_next;
    logic [srsw_pkg::TMO_W-1:0]       now_reg, now_next;
    logic [srsw_pkg::TMO_W-1:0]       tmo_reg, tmo_next;
    logic [srsw_pkg::STEP_W-1:0]      step_reg, step_next;
    srsw_pkg::status_t                rstat_reg, rstat_next;
    logic [srsw_pkg::SEQ_W-1:0]       rseq_reg, rseq_next;
    logic                             out_valid_reg, out_valid_next;
    srsw_pkg::status_t                out_status_reg, out_status_next;
    logic [srsw_pkg::SEQ_W-1:0]       out_seq_reg, out_seq_next;
    logic [srsw_pkg::SEQ_W-1:0]       out_base_reg, out_base_next;
    logic [srsw_pkg::SEQ_W-1:0]       out_nxt_reg, out_nxt_next;
    logic [srsw_pkg::CNT_W-1:0]       out_flight_reg, out_flight_next;
    logic [srsw_pkg::TMO_W-1:0]       out_tmo_reg, out_tmo_next;
    logic [srsw_pkg::SEQ_W-1:0]       flight;
    logic [srsw_pkg::SEQ_W-1:0]       ack_off;
    logic [srsw_pkg::TMO_W-1:0]       elapsed;
    logic [srsw_pkg::TMO_W:0]         tmo_sum;

    assign flight  = nxt_reg - base_reg;
    assign ack_off = cmd_reg.ack_seq - base_reg;
    assign elapsed = now_reg - tq_stat.head_stamp;
    assign tmo_sum = {1'b0, tmo_reg} + (srsw_pkg::TMO_W + 1)'(step_reg);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        base_next       = base_reg;
        nxt_next        = nxt_reg;
        acked_next      = acked_reg;
        now_next        = now_reg;
        tmo_next        = tmo_reg;
        step_next       = step_reg;
        rstat_next      = rstat_reg;
        rseq_next       = rseq_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_seq_next    = out_seq_reg;
        out_base_next   = out_base_reg;
        out_nxt_next    = out_nxt_reg;
        out_flight_next = out_flight_reg;
        out_tmo_next    = out_tmo_reg;
        cmd_pop         = 1'b0;
        tq_ctl.op       = srsw_pkg::TQ_NONE;
        tq_ctl.seq      = cmd_reg.ack_seq;
        tq_ctl.stamp    = now_reg;

        unique case (state_reg)
            srsw_pkg::BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd;
                    state_next = srsw_pkg::BK_EXEC;
                end
            end
            srsw_pkg::BK_EXEC:
            begin
                rseq_next  = '0;
                state_next = srsw_pkg::BK_RESULT;
                unique case (cmd_reg.op)
                    srsw_pkg::OP_SEND:
                    begin
                        if (flight >= srsw_pkg::SEQ_W'(srsw_pkg::FULL_LIMIT))
                        begin
                            rstat_next = srsw_pkg::ST_FULL;
                        end
                        else
                        begin
                            acked_next[nxt_reg] = 1'b0;
                            tq_ctl.op           = srsw_pkg::TQ_PUSH;
                            tq_ctl.seq          = nxt_reg;
                            nxt_next            = nxt_reg + 1'b1;
                            rstat_next          = srsw_pkg::ST_SENT;
                            rseq_next           = nxt_reg;
                        end
                    end
                    srsw_pkg::OP_ACK:
                    begin
                        rseq_next = cmd_reg.ack_seq;
                        if (ack_off >= flight)
                        begin
                            rstat_next = srsw_pkg::ST_OUTSIDE;
                        end
                        else if (acked_reg[cmd_reg.ack_seq])
                        begin
                            rstat_next = srsw_pkg::ST_DUP;
                        end
                        else
                        begin
                            acked_next[cmd_reg.ack_seq] = 1'b1;
                            tq_ctl.op                   = srsw_pkg::TQ_REMOVE;
                            rstat_next                  = srsw_pkg::ST_ACKED;
                            if (cmd_reg.ack_seq == base_reg)
                            begin
                                state_next = srsw_pkg::BK_SLIDE;
                            end
                        end
                    end
                    srsw_pkg::OP_TICK:
                    begin
                        now_next   = now_reg + 1'b1;
                        rstat_next = srsw_pkg::ST_IDLE;
                        if (tq_stat.count != '0)
                        begin
                            state_next = srsw_pkg::BK_TCHK;
                        end
                    end
                    default:
                    begin
                        rstat_next = srsw_pkg::ST_IDLE;
                    end
                endcase
            end
            srsw_pkg::BK_SLIDE:
            begin
                if ((base_reg != nxt_reg) && acked_reg[base_reg])
                begin
                    acked_next[base_reg] = 1'b0;
                    base_next            = base_reg + 1'b1;
                end
                else
                begin
                    state_next = srsw_pkg::BK_RESULT;
                end
            end
            srsw_pkg::BK_TCHK:
            begin
                state_next = (elapsed > tmo_reg) ? srsw_pkg::BK_TBACK : srsw_pkg::BK_RESULT;
            end
            srsw_pkg::BK_TBACK:
            begin
                tmo_next   = tmo_sum[srsw_pkg::TMO_W] ? '1 : tmo_sum[srsw_pkg::TMO_W-1:0];
                tq_ctl.op  = srsw_pkg::TQ_ROTATE;
                rstat_next = srsw_pkg::ST_RETX;
                rseq_next  = tq_stat.head_seq;
                state_next = srsw_pkg::BK_RESULT;
            end
            srsw_pkg::BK_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = rstat_reg;
                    out_seq_next    = rseq_reg;
                    out_base_next   = base_reg;
                    out_nxt_next    = nxt_reg;
                    out_flight_next = srsw_pkg::CNT_W'(flight);
                    out_tmo_next    = tmo_reg;
                    state_next      = srsw_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = srsw_pkg::BK_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                srsw_pkg::CFG_RTO:  tmo_next  = cfg_data;
                srsw_pkg::CFG_STEP: step_next = cfg_data[srsw_pkg::STEP_W-1:0];
                default:            step_next = step_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srsw_pkg::BK_IDLE;
            base_reg      <= '0;
            nxt_reg       <= '0;
            acked_reg     <= '0;
            now_reg       <= '0;
            tmo_reg       <= srsw_pkg::TMO_RST;
            step_reg      <= srsw_pkg::STEP_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            nxt_reg       <= nxt_next;
            acked_reg     <= acked_next;
            now_reg       <= now_next;
            tmo_reg       <= tmo_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        rstat_reg      <= rstat_next;
        rseq_reg       <= rseq_next;
        out_status_reg <= out_status_next;
        out_seq_reg    <= out_seq_next;
        out_base_reg   <= out_base_next;
        out_nxt_reg    <= out_nxt_next;
        out_flight_reg <= out_flight_next;
        out_tmo_reg    <= out_tmo_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign seq          = out_seq_reg;
    assign window_base  = out_base_reg;
    assign next_seq_out = out_nxt_reg;
    assign in_flight    = out_flight_reg;
    assign timeout_now  = out_tmo_reg;

`ifndef SYNTHESIS
    a_flight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        flight <= srsw_pkg::SEQ_W'(srsw_pkg::FULL_LIMIT))
        else $error("window holds more words than allowed");

    a_queue_le_flight: assert property (@(posedge clk) disable iff (!rst_n)
        srsw_pkg::SEQ_W'(tq_stat.count) <= flight)
        else $error("timer queue longer than outstanding window");

    a_out_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == srsw_pkg::BK_RESULT))
        else $error("result word raised outside result state");

    a_tmo_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |=> tmo_reg >= $past(tmo_reg))
        else $error("timeout decreased without a register write");
`endif

endmodule

`default_nettype wire

@@ sv/selective_repeat_send_window.sv @@
// Sender window of a selective-repeat link: sequence numbers, ack tracking
// and retransmission timers.
// Input channel (in_valid/in_stall): kind 0 requests a send, kind 1 carries
// an ack for ack_seq, kind 2 is one timer tick, kind 3 does nothing.
// Output channel (out_valid/out_stall): one word per input word, in order,
// with status, sequence, window base, next sequence, in-flight count and
// the current timeout.
// Configuration: cfg_we with cfg_index 0 loads the timeout (also restarting
// the current timeout), index 1 the backoff step; write only while idle.
// A two-word command queue decouples input from the executing back end.
// Each word passes the back-end states idle, exec and result before its
// result word is registered; an ack at the base also passes the slide
// state, where the base slides past acked slots (at most 16), and a tick
// with timers queued passes the timer check, and backoff when it retransmits.
// The back end takes one word at a time: it pops the next word only once
// the result of the last one has been registered.
// Reset clears the window, flags, timer queue and tick counter and loads
// the timeout with 1000000 ticks and the backoff step with 1.
// When out_stall holds, the result word stays put; the back end waits with
// the next result and the command queue fills, raising in_stall when full.
`default_nettype none

module selective_repeat_send_window (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [srsw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [srsw_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [srsw_pkg::KIND_W-1:0]       kind,
    input  wire logic [srsw_pkg::SEQ_W-1:0]        ack_seq,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [srsw_pkg::STATUS_W-1:0]          status,
    output logic [srsw_pkg::SEQ_W-1:0]             seq,
    output logic [srsw_pkg::SEQ_W-1:0]             window_base,
    output logic [srsw_pkg::SEQ_W-1:0]             next_seq_out,
    output logic [srsw_pkg::CNT_W-1:0]             in_flight,
    output logic [srsw_pkg::TMO_W-1:0]             timeout_now
);

    logic                  cmd_valid;
    srsw_pkg::cmd_t        cmd;
    logic                  cmd_pop;
    srsw_pkg::tq_ctl_t     tq_ctl;
    srsw_pkg::tq_stat_t    tq_stat;

    srsw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .ack_seq   (ack_seq),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    srsw_tmrq u_tmrq (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (tq_ctl),
        .stat  (tq_stat)
    );

    srsw_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .tq_ctl       (tq_ctl),
        .tq_stat      (tq_stat),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .seq          (seq),
        .window_base  (window_base),
        .next_seq_out (next_seq_out),
        .in_flight    (in_flight),
        .timeout_now  (timeout_now)
    );

endmodule

`default_nettype wire
